/* sv/itm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package itm_pkg;

    localparam int unsigned COLOR_BITS = 16;

    // Register indexes on the configuration port (word index = paddr[2]).
    localparam int unsigned ADDR_BITS = 3;
    localparam logic REG_TRANSPARENCY_ENABLE = 1'b0;

    typedef logic [COLOR_BITS-1:0] t_color;

    typedef struct packed {
        t_color target_color;
        t_color canvas_color;
        logic   frame_end;
    } t_pixel;

    // Keep-rule run tracker.
    typedef enum logic [1:0] {
        RUN_NONE = 2'd0,
        RUN_OPEN = 2'd1,
        RUN_MARK = 2'd2
    } t_run_phase;

    // Greedy-rule match run length: none, one, two or more.
    typedef enum logic [1:0] {
        GRUN_NONE  = 2'd0,
        GRUN_ONE   = 2'd1,
        GRUN_MULTI = 2'd2
    } t_greedy_run;

    typedef struct packed {
        logic any_match;
        logic see_through;
        logic all_match;
        logic keep_nonempty;
        logic greedy_nonempty;
        logic lone;
    } t_frame_flags;

    localparam t_frame_flags FLAGS_CLEAR = '{
        any_match:       1'b0,
        see_through:     1'b0,
        all_match:       1'b1,
        keep_nonempty:   1'b0,
        greedy_nonempty: 1'b0,
        lone:            1'b0
    };

    // Single-bit part of one result.
    typedef struct packed {
        logic keep_mark;
        logic greedy_mark;
        logic greedy_backfill_prev;
        logic any_match;
        logic needs_see_through;
        logic all_match;
        logic keep_nonempty;
        logic greedy_nonempty;
        logic lone_found;
        logic frame_done;
    } t_result_bits;

endpackage

`default_nettype wire

/* sv/interframe_transparency_masker.sv */
`timescale 1ns / 1ps
`default_nettype none

// Interframe transparency masker. Pixels of a frame region arrive in raster
// order, one request per pixel, each carrying the wanted colour id and the id
// already on the canvas (id 0 is transparent). Every request yields exactly one
// result: the keep, greedy and lone mask decisions for that pixel, plus
// backfill counts telling how many immediately preceding pixels the keep or
// lone mask now also covers, and whether the greedy mask takes back the
// previous pixel. Frame flags are valid on the result of the pixel flagged as
// frame end and read zero otherwise; all run state clears after that pixel.
// Rate: one pixel per clock sustained while i_stall stays low. A request is
// held in the input register, the rule logic works off that register and the
// run state, and the result is registered in the output register when the
// pixel advances, which it does only while the output register is free. The
// input register can still take one pixel while a finished result waits on
// i_stall; once both registers are full, o_stall holds off new requests.
// Backfill counts saturate at 2**COUNT_BITS - 1. Writing transparency_enable
// (register 0, byte address 0) to zero forces every mask output to zero; write
// it only while no pixels are in flight.

module interframe_transparency_masker
    import itm_pkg::*;
#(
    parameter int unsigned COUNT_BITS = 28
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,

    // Pixel requests.
    input  wire                     i_valid,
    output logic                    o_stall,
    input  wire [COLOR_BITS-1:0]    i_target_color,
    input  wire [COLOR_BITS-1:0]    i_canvas_color,
    input  wire                     i_frame_end,

    // Results.
    output logic                    o_valid,
    input  wire                     i_stall,
    output logic                    o_keep_mark,
    output logic [COUNT_BITS-1:0]   o_keep_backfill,
    output logic                    o_greedy_mark,
    output logic                    o_greedy_backfill_prev,
    output logic [COUNT_BITS-1:0]   o_lone_backfill,
    output logic                    o_any_match,
    output logic                    o_needs_see_through,
    output logic                    o_all_match,
    output logic                    o_keep_nonempty,
    output logic                    o_greedy_nonempty,
    output logic                    o_lone_found,
    output logic                    o_frame_done,

    // Configuration.
    input  wire                     psel,
    input  wire                     penable,
    input  wire                     pwrite,
    input  wire [ADDR_BITS-1:0]     paddr,
    input  wire [31:0]              pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic                  r_transparency_enable;
    logic                  w_cfg_write;
    logic                  w_reg_index;

    t_pixel                w_in_pixel;
    t_pixel                w_stage_pixel;
    logic                  w_stage_valid;
    logic                  w_out_free;
    logic                  w_advance;

    t_result_bits          w_core_bits;
    logic [COUNT_BITS-1:0] w_core_keep_backfill;
    logic [COUNT_BITS-1:0] w_core_lone_backfill;
    t_result_bits          w_out_bits;

    // Configuration register: word index sits above the byte offset.
    assign pready      = 1'b1;
    assign w_reg_index = paddr[2];
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_transparency_enable <= 1'b1;
        end else if (w_cfg_write && w_reg_index == REG_TRANSPARENCY_ENABLE) begin
            r_transparency_enable <= pwdata[0];
        end
    end

    always_comb begin
        unique case (w_reg_index)
            REG_TRANSPARENCY_ENABLE: prdata = {31'd0, r_transparency_enable};
            default:                 prdata = '0;
        endcase
    end

    // Pixel enters the input register; advance it when the result slot frees.
    assign w_in_pixel = '{
        target_color: i_target_color,
        canvas_color: i_canvas_color,
        frame_end:    i_frame_end
    };
    assign w_advance = w_stage_valid && w_out_free;

    itm_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_pixel   (w_in_pixel),
        .i_advance (w_advance),
        .o_valid   (w_stage_valid),
        .o_pixel   (w_stage_pixel)
    );

    // Run rules: state updates exactly when the pixel moves into the result.
    itm_rule_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_rule_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_enable        (r_transparency_enable),
        .i_fire          (w_advance),
        .i_pixel         (w_stage_pixel),
        .o_bits          (w_core_bits),
        .o_keep_backfill (w_core_keep_backfill),
        .o_lone_backfill (w_core_lone_backfill)
    );

    itm_out_stage #(
        .COUNT_BITS (COUNT_BITS)
    ) u_out_stage (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (w_advance),
        .i_bits          (w_core_bits),
        .i_keep_backfill (w_core_keep_backfill),
        .i_lone_backfill (w_core_lone_backfill),
        .i_stall         (i_stall),
        .o_free          (w_out_free),
        .o_valid         (o_valid),
        .o_bits          (w_out_bits),
        .o_keep_backfill (o_keep_backfill),
        .o_lone_backfill (o_lone_backfill)
    );

    assign o_keep_mark            = w_out_bits.keep_mark;
    assign o_greedy_mark          = w_out_bits.greedy_mark;
    assign o_greedy_backfill_prev = w_out_bits.greedy_backfill_prev;
    assign o_any_match            = w_out_bits.any_match;
    assign o_needs_see_through    = w_out_bits.needs_see_through;
    assign o_all_match            = w_out_bits.all_match;
    assign o_keep_nonempty        = w_out_bits.keep_nonempty;
    assign o_greedy_nonempty      = w_out_bits.greedy_nonempty;
    assign o_lone_found           = w_out_bits.lone_found;
    assign o_frame_done           = w_out_bits.frame_done;

endmodule

`default_nettype wire

/* sv/itm_in_stage.sv */
`timescale 1ns / 1ps
`default_nettype none

module itm_in_stage
    import itm_pkg::*;
(
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  wire    i_valid,
    output logic   o_stall,
    input  t_pixel i_pixel,
    input  wire    i_advance,
    output logic   o_valid,
    output t_pixel o_pixel
);

    logic   r_valid;
    t_pixel r_pixel;
    logic   w_load;

    // Take a new request when empty or when the held one moves on.
    assign o_stall = r_valid && !i_advance;
    assign w_load  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_pixel <= i_pixel;
        end
    end

    assign o_valid = r_valid;
    assign o_pixel = r_pixel;

endmodule

`default_nettype wire

/* sv/itm_rule_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module itm_rule_core
    import itm_pkg::*;
#(
    parameter int unsigned COUNT_BITS = 28
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_enable,
    input  wire                     i_fire,
    input  t_pixel                  i_pixel,
    output t_result_bits            o_bits,
    output logic [COUNT_BITS-1:0]   o_keep_backfill,
    output logic [COUNT_BITS-1:0]   o_lone_backfill
);

    t_run_phase              r_run_phase,     n_run_phase;
    logic [COUNT_BITS-1:0]   r_pending_count, n_pending_count;
    t_color                  r_prev_color,    n_prev_color;
    logic                    r_prev_marked,   n_prev_marked;
    t_greedy_run             r_greedy_run,    n_greedy_run;
    t_frame_flags            r_flags,         n_flags;

    logic                    w_match;
    logic                    w_transparent;
    logic                    w_member;
    logic                    w_kmark;
    logic                    w_gmark;
    logic                    w_gprev;
    logic                    w_lone;
    logic [COUNT_BITS-1:0]   w_kfill;
    logic [COUNT_BITS-1:0]   w_lfill;
    t_color                  w_shown;
    t_frame_flags            w_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_phase     <= RUN_NONE;
            r_pending_count <= '0;
            r_prev_color    <= '0;
            r_prev_marked   <= 1'b0;
            r_greedy_run    <= GRUN_NONE;
            r_flags         <= FLAGS_CLEAR;
        end else if (i_fire) begin
            r_run_phase     <= n_run_phase;
            r_pending_count <= n_pending_count;
            r_prev_color    <= n_prev_color;
            r_prev_marked   <= n_prev_marked;
            r_greedy_run    <= n_greedy_run;
            r_flags         <= n_flags;
        end
    end

    always_comb begin
        w_match       = i_pixel.target_color == i_pixel.canvas_color;
        w_transparent = i_pixel.target_color == '0;
        w_member      = w_match || w_transparent;
        w_shown       = r_prev_marked ? '0 : r_prev_color;

        w_kmark         = 1'b0;
        w_kfill         = '0;
        w_lfill         = '0;
        w_lone          = 1'b0;
        n_run_phase     = r_run_phase;
        n_pending_count = r_pending_count;

        // Keep rule.
        if (!w_member) begin
            if (r_run_phase == RUN_OPEN && !r_prev_marked) begin
                w_lfill = r_pending_count;
                w_lone  = 1'b1;
            end
            n_run_phase     = RUN_NONE;
            n_pending_count = '0;
        end else begin
            unique case (r_run_phase)
                RUN_NONE: begin
                    n_run_phase     = RUN_OPEN;
                    n_pending_count = COUNT_BITS'(1);
                end
                RUN_OPEN: begin
                    if (i_pixel.target_color != w_shown) begin
                        w_kfill         = r_pending_count;
                        w_kmark         = 1'b1;
                        n_run_phase     = RUN_MARK;
                        n_pending_count = '0;
                    end else if (r_pending_count != '1) begin
                        n_pending_count = r_pending_count + COUNT_BITS'(1);
                    end
                end
                RUN_MARK: begin
                    w_kmark = 1'b1;
                end
                default: begin
                    n_run_phase     = RUN_NONE;
                    n_pending_count = '0;
                end
            endcase
        end
        n_prev_color  = i_pixel.target_color;
        n_prev_marked = w_kmark;

        // Greedy rule.
        w_gmark = 1'b0;
        w_gprev = 1'b0;
        if (!w_match) begin
            n_greedy_run = GRUN_NONE;
        end else if (r_greedy_run == GRUN_NONE) begin
            n_greedy_run = GRUN_ONE;
        end else begin
            w_gprev      = r_greedy_run == GRUN_ONE;
            w_gmark      = 1'b1;
            n_greedy_run = GRUN_MULTI;
        end

        // Drop every mark while transparency is off.
        if (!i_enable) begin
            w_kmark = 1'b0;
            w_kfill = '0;
            w_gmark = 1'b0;
            w_gprev = 1'b0;
            w_lfill = '0;
            w_lone  = 1'b0;
        end

        w_flags                 = r_flags;
        w_flags.any_match       = r_flags.any_match | w_match;
        w_flags.all_match       = r_flags.all_match & w_match;
        w_flags.see_through     = r_flags.see_through | w_transparent;
        w_flags.keep_nonempty   = r_flags.keep_nonempty | w_kmark;
        w_flags.greedy_nonempty = r_flags.greedy_nonempty | w_gmark;
        w_flags.lone            = r_flags.lone | w_lone;
        n_flags                 = w_flags;

        o_bits                      = '0;
        o_bits.keep_mark            = w_kmark;
        o_bits.greedy_mark          = w_gmark;
        o_bits.greedy_backfill_prev = w_gprev;
        o_bits.frame_done           = i_pixel.frame_end;

        // Report flags on the last pixel and clear for the next frame.
        if (i_pixel.frame_end) begin
            o_bits.any_match         = w_flags.any_match;
            o_bits.needs_see_through = w_flags.see_through;
            o_bits.all_match         = w_flags.all_match;
            o_bits.keep_nonempty     = w_flags.keep_nonempty;
            o_bits.greedy_nonempty   = w_flags.greedy_nonempty;
            o_bits.lone_found        = w_flags.any_match & w_flags.lone;
            n_run_phase     = RUN_NONE;
            n_pending_count = '0;
            n_prev_color    = '0;
            n_prev_marked   = 1'b0;
            n_greedy_run    = GRUN_NONE;
            n_flags         = FLAGS_CLEAR;
        end

        o_keep_backfill = w_kfill;
        o_lone_backfill = w_lfill;
    end

endmodule

`default_nettype wire

/* sv/itm_out_stage.sv */
`timescale 1ns / 1ps
`default_nettype none

module itm_out_stage
    import itm_pkg::*;
#(
    parameter int unsigned COUNT_BITS = 28
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_load,
    input  t_result_bits            i_bits,
    input  wire [COUNT_BITS-1:0]    i_keep_backfill,
    input  wire [COUNT_BITS-1:0]    i_lone_backfill,
    input  wire                     i_stall,
    output logic                    o_free,
    output logic                    o_valid,
    output t_result_bits            o_bits,
    output logic [COUNT_BITS-1:0]   o_keep_backfill,
    output logic [COUNT_BITS-1:0]   o_lone_backfill
);

    logic                  r_valid;
    t_result_bits          r_bits;
    logic [COUNT_BITS-1:0] r_keep_backfill;
    logic [COUNT_BITS-1:0] r_lone_backfill;

    // Free when empty or when the held result is taken this cycle.
    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bits          <= i_bits;
            r_keep_backfill <= i_keep_backfill;
            r_lone_backfill <= i_lone_backfill;
        end
    end

    assign o_valid         = r_valid;
    assign o_bits          = r_bits;
    assign o_keep_backfill = r_keep_backfill;
    assign o_lone_backfill = r_lone_backfill;

endmodule

`default_nettype wire
